// File: sv/czsg_pkg.sv
`default_nettype none

package czsg_pkg;

   // register indexes on the csr port
   localparam logic [2:0] REG_SAFE_THR  = 3'd0;
   localparam logic [2:0] REG_WARN_THR  = 3'd1;
   localparam logic [2:0] REG_SAFE_SPD  = 3'd2;
   localparam logic [2:0] REG_WARN_MIN  = 3'd3;
   localparam logic [2:0] REG_WARN_MAX  = 3'd4;

   // zone codes
   localparam logic [1:0] ZONE_SAFE     = 2'd0;
   localparam logic [1:0] ZONE_WARN     = 2'd1;
   localparam logic [1:0] ZONE_DANGER   = 2'd2;

   // register reset values
   localparam logic [8:0] SAFE_THR_RST  = 9'd100;
   localparam logic [8:0] WARN_THR_RST  = 9'd50;
   localparam logic [6:0] SAFE_SPD_RST  = 7'd50;
   localparam logic [6:0] WARN_MIN_RST  = 7'd30;
   localparam logic [6:0] WARN_MAX_RST  = 7'd40;

   // raw reading window and substitute, cm
   localparam logic [15:0] RAW_MIN_CM   = 16'd2;
   localparam logic [15:0] RAW_MAX_CM   = 16'd400;
   localparam logic [8:0]  RAW_SUBST_CM = 9'd400;

   // filter, Q9.8 cm
   localparam logic [7:0]  FILT_GAIN    = 8'd77;
   localparam logic [16:0] SMOOTH_RST   = 17'd51200;
   localparam logic [16:0] SMOOTH_MAX   = 17'd102400;

   // result beat, last field in the lowest bits
   typedef struct packed {
      logic [1:0] pad;
      logic       led_red;
      logic       led_yellow;
      logic       buzzer_pulse;
      logic       brake;
      logic [8:0] shown_cm;
      logic [6:0] drive_pct;
      logic [1:0] zone;
   } rsp_beat_type;

endpackage

`default_nettype wire

// File: sv/collision_zone_speed_governor.sv
`default_nettype none

// Collision-zone speed governor. Each req beat carries one raw range reading
// in cm; readings outside 2..400 count as 400. The reading updates a Q9.8
// exponential filter (gain 77/256, starts at 200 cm), and one rsp beat comes
// back per reading with the zone, the drive duty, the filtered distance
// rounded to whole cm and the brake, buzzer and lamp commands. Work is done
// by a small sequencer: filter multiply, filter update, zone decode, then a
// restoring divider (one subtract-compare per cycle) for the warning-zone
// speed ramp, then a final clamp. The divide is skipped outside the warning
// zone or with unordered thresholds. req_tready is high only in idle, so a
// new reading is taken only once the last one has left the sequencer. The
// result sits in an output register, so the next reading is taken while rsp
// waits; a result that is done while the previous one still waits holds in
// the last step. Csr writes are meant for idle time only.
module collision_zone_speed_governor
   import czsg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // reading channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] range_cm
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [1:0] zone, [8:2] drive_pct,
                                         // [17:9] shown_cm, [18] brake,
                                         // [19] buzzer_pulse, [20] led_yellow,
                                         // [21] led_red, [23:22] zero
   // config write port
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_addr,
   input  wire logic [8:0]  csr_wdata
);

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;  // diff * gain
   localparam logic [2:0] ST_FILT = 3'd2;  // round, add, clamp
   localparam logic [2:0] ST_ZONE = 3'd3;  // compares, ramp numerator
   localparam logic [2:0] ST_DIV  = 3'd4;  // one quotient bit per cycle
   localparam logic [2:0] ST_FIN  = 3'd5;  // clamp duty, load output

   // control / state registers
   logic [2:0]   state_ff,    state_in;
   logic [16:0]  smoothed_ff, smoothed_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [2:0]   cnt_ff,      cnt_in;
   logic [8:0]   safe_thr_ff, warn_thr_ff;
   logic [6:0]   safe_spd_ff, wmin_ff, wmax_ff;

   // payload registers
   logic [8:0]        raw_ff,  raw_in;
   logic signed [25:0] prod_ff, prod_in;
   logic [1:0]        zone_ff, zone_in;
   logic              neg_ff,  neg_in;
   logic [23:0]       rem_ff,  rem_in;
   logic [23:0]       dsh_ff,  dsh_in;
   logic [7:0]        quo_ff,  quo_in;
   rsp_beat_type      rsp_ff,  rsp_in;

   // datapath nets
   logic               raw_ok;
   logic [8:0]         raw_sel;
   logic signed [17:0] diff_w;
   logic signed [25:0] round_w;
   logic signed [25:0] sum_w;
   logic [16:0]        safe_q_w, warn_q_w, off_w, den_w;
   logic               ordered_w, span_neg_w;
   logic [6:0]         span_mag_w;
   logic [23:0]        num_w;
   logic [24:0]        trial_w;
   logic signed [9:0]  mn_s, mx_s, q_s, spd_w, spd_lo;
   logic [17:0]        shown_w;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   // input range check
   assign raw_ok  = (req_tdata >= RAW_MIN_CM) && (req_tdata <= RAW_MAX_CM);
   assign raw_sel = raw_ok ? req_tdata[8:0] : RAW_SUBST_CM;

   // filter: (raw*256 - s) * 77, floor((p + 128) / 256), added to s
   assign diff_w  = signed'({1'b0, raw_ff, 8'd0}) - signed'({1'b0, smoothed_ff});
   assign round_w = (prod_ff + 26'sd128) >>> 8;
   assign sum_w   = signed'({9'd0, smoothed_ff}) + round_w;

   // zone decode and ramp operands
   assign safe_q_w   = {safe_thr_ff, 8'd0};
   assign warn_q_w   = {warn_thr_ff, 8'd0};
   assign ordered_w  = safe_thr_ff > warn_thr_ff;
   assign span_neg_w = wmin_ff > wmax_ff;
   assign span_mag_w = span_neg_w ? (wmin_ff - wmax_ff) : (wmax_ff - wmin_ff);
   assign off_w      = smoothed_ff - warn_q_w;
   assign num_w      = {7'd0, off_w} * {17'd0, span_mag_w};
   assign den_w      = {safe_thr_ff - warn_thr_ff, 8'd0};

   // shared subtract-compare of the divider
   assign trial_w = {1'b0, rem_ff} - {1'b0, dsh_ff};

   // duty clamp
   assign mn_s   = signed'({3'd0, wmin_ff});
   assign mx_s   = signed'({3'd0, wmax_ff});
   assign q_s    = signed'({2'd0, quo_ff});
   assign spd_w  = neg_ff ? (mn_s - q_s) : (mn_s + q_s);
   assign spd_lo = (spd_w < mn_s) ? mn_s : spd_w;

   assign shown_w = {1'b0, smoothed_ff} + 18'd128;

   always_comb begin
      state_in     = state_ff;
      smoothed_in  = smoothed_ff;
      rsp_valid_in = rsp_valid_ff;
      cnt_in       = cnt_ff;
      raw_in       = raw_ff;
      prod_in      = prod_ff;
      zone_in      = zone_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      dsh_in       = dsh_ff;
      quo_in       = quo_ff;
      rsp_in       = rsp_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               raw_in   = raw_sel;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = 26'(diff_w) * signed'({18'd0, FILT_GAIN});
            state_in = ST_FILT;
         end
         ST_FILT: begin
            priority if (sum_w < 26'sd0) begin
               smoothed_in = 17'd0;
            end else if (sum_w > signed'({9'd0, SMOOTH_MAX})) begin
               smoothed_in = SMOOTH_MAX;
            end else begin
               smoothed_in = sum_w[16:0];
            end
            state_in = ST_ZONE;
         end
         ST_ZONE: begin
            neg_in = span_neg_w;
            rem_in = num_w;
            dsh_in = {den_w, 7'd0};
            quo_in = 8'd0;
            cnt_in = 3'd7;
            priority if (smoothed_ff > safe_q_w) begin
               zone_in  = ZONE_SAFE;
               state_in = ST_FIN;
            end else if (smoothed_ff >= warn_q_w) begin
               zone_in  = ZONE_WARN;
               state_in = ordered_w ? ST_DIV : ST_FIN;
            end else begin
               zone_in  = ZONE_DANGER;
               state_in = ST_FIN;
            end
         end
         ST_DIV: begin
            if (!trial_w[24]) begin
               rem_in = trial_w[23:0];
               quo_in = {quo_ff[6:0], 1'b1};
            end else begin
               quo_in = {quo_ff[6:0], 1'b0};
            end
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff - 3'd1;
            if (cnt_ff == 3'd0) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_in              = '0;
               rsp_in.zone         = zone_ff;
               rsp_in.shown_cm     = shown_w[16:8];
               unique case (zone_ff)
                  ZONE_SAFE: begin
                     rsp_in.drive_pct = safe_spd_ff;
                  end
                  ZONE_WARN: begin
                     rsp_in.drive_pct  = (spd_lo > mx_s) ? wmax_ff : spd_lo[6:0];
                     rsp_in.led_yellow = 1'b1;
                  end
                  default: begin
                     rsp_in.drive_pct    = 7'd0;
                     rsp_in.brake        = 1'b1;
                     rsp_in.buzzer_pulse = 1'b1;
                     rsp_in.led_red      = 1'b1;
                  end
               endcase
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         smoothed_ff  <= SMOOTH_RST;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= 3'd0;
         safe_thr_ff  <= SAFE_THR_RST;
         warn_thr_ff  <= WARN_THR_RST;
         safe_spd_ff  <= SAFE_SPD_RST;
         wmin_ff      <= WARN_MIN_RST;
         wmax_ff      <= WARN_MAX_RST;
      end else begin
         state_ff     <= state_in;
         smoothed_ff  <= smoothed_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         if (csr_we) begin
            unique case (csr_addr)
               REG_SAFE_THR: safe_thr_ff <= csr_wdata;
               REG_WARN_THR: warn_thr_ff <= csr_wdata;
               REG_SAFE_SPD: safe_spd_ff <= csr_wdata[6:0];
               REG_WARN_MIN: wmin_ff     <= csr_wdata[6:0];
               REG_WARN_MAX: wmax_ff     <= csr_wdata[6:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      raw_ff  <= raw_in;
      prod_ff <= prod_in;
      zone_ff <= zone_in;
      neg_ff  <= neg_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quo_ff  <= quo_in;
      rsp_ff  <= rsp_in;
   end

`ifndef SYNTHESIS
   a_filt_bound: assert property (@(posedge clock) disable iff (reset)
      smoothed_ff <= SMOOTH_MAX)
      else $error("filter state out of range");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_MUL))
      else $error("accepted reading did not start the sequencer");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FIN))
      else $error("result appeared outside the final step");

   a_danger_stops: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.zone == ZONE_DANGER)) |->
         (rsp_ff.drive_pct == 7'd0 && rsp_ff.brake && rsp_ff.led_red))
      else $error("danger result without stop");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> $stable(rsp_ff))
      else $error("waiting result overwritten");
`endif

endmodule

`default_nettype wire

// File: test/tb_collision_zone_speed_governor.sv
`timescale 1ns / 100ps

module tb_collision_zone_speed_governor;
   import czsg_pkg::*;

   // ---------------------------------------------------------------------
   // DUT hookup. Inputs are driven on the falling edge, outputs are looked
   // at on the rising edge, so nothing depends on event order in a step.
   // ---------------------------------------------------------------------
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;    // [15:0] range_cm
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;          // [1:0] zone, [8:2] drive_pct, [17:9] shown_cm,
                                    // [18] brake, [19] buzzer_pulse, [20] led_yellow,
                                    // [21] led_red, [23:22] zero
   logic        csr_we     = 1'b0;
   logic [2:0]  csr_addr   = REG_SAFE_THR;
   logic [8:0]  csr_wdata  = '0;

   collision_zone_speed_governor i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Test plan constants
   // ---------------------------------------------------------------------
   // Directed readings: the range extremes, every out-of-window flavor
   // (below 2, above 400, top bit set), then runs that pull the filter down
   // through warning into danger. The first rows follow reset and come out
   // in the safe zone at the reset duty; their rounded distance is typed in.
   localparam int N_DIRECTED = 23;
   localparam logic [15:0] DIRECTED_RANGE [N_DIRECTED] = '{
      16'd400, 16'd0, 16'hFFFF, 16'd1, 16'd401, 16'd2, 16'd3, 16'd399,
      16'h8000, 16'h7FFF,
      16'd40, 16'd40, 16'd40, 16'd40, 16'd40, 16'd40,
      16'd20, 16'd20, 16'd20, 16'd20,
      16'd2, 16'd2, 16'd2
   };
   localparam int PINNED_ROWS = 3;
   localparam logic [8:0] PINNED_SHOWN [PINNED_ROWS] = '{9'd260, 9'd302, 9'd332};

   // Register settings, one per phase; phase 0 runs on the reset values.
   // Columns follow REG_ORDER: safe thr, warn thr, safe duty, warn min, warn max.
   localparam int N_PHASES       = 8;
   localparam int PRESSURE_PHASE = 7;
   localparam int HOLD_OFF_LEN   = 400;
   localparam logic [2:0] REG_ORDER [5] = '{
      REG_SAFE_THR, REG_WARN_THR, REG_SAFE_SPD, REG_WARN_MIN, REG_WARN_MAX
   };
   localparam int SETTING [N_PHASES][5] = '{
      '{100,  50,  50,  30,  40},   // reset values, not written
      '{200,  20, 100,   0, 100},   // wide ramp, full duty span
      '{  0,   0,   0,   0,   0},   // all at the low end
      '{400, 400, 100, 100, 100},   // equal thresholds -> warn duty is min
      '{ 60, 120,  37,  10,  90},   // thresholds swapped
      '{150,  40,  64,  80,  20},   // min above max -> duty pinned to max
      '{511, 300, 127,   0, 127},   // past the stated ranges, full width
      '{100,  50,  50,  30,  40}    // back to defaults, output stall phase
   };
   localparam int RANDOM_PER_PHASE = 85;

   // ---------------------------------------------------------------------
   // Predictor state: our own copy of the registers and the Q9.8 filter
   // ---------------------------------------------------------------------
   logic [8:0]  thr_safe, thr_warn;
   logic [6:0]  duty_safe, duty_min, duty_max;
   logic [16:0] filt_q8;

   // Works out the result beat for one reading and advances the filter.
   function automatic rsp_beat_type governor_step(input logic [15:0] range_cm);
      longint raw, f, prod, safe_q, warn_q, mn, mx, spd;
      rsp_beat_type b;
      b = '0;
      raw = range_cm;
      if (raw < RAW_MIN_CM || raw > RAW_MAX_CM)
         raw = RAW_SUBST_CM;
      // gain 77/256, round to nearest with ties up: floor((p + 128) / 256)
      prod = (raw * 256 - longint'(filt_q8)) * FILT_GAIN + 128;
      f = longint'(filt_q8) + (prod >>> 8);
      if (f < 0)
         f = 0;
      if (f > SMOOTH_MAX)
         f = SMOOTH_MAX;
      filt_q8 = f[16:0];

      safe_q = longint'(thr_safe) * 256;
      warn_q = longint'(thr_warn) * 256;
      if (f > safe_q) begin
         b.zone      = ZONE_SAFE;
         b.drive_pct = duty_safe;
      end else if (f >= warn_q) begin
         mn  = duty_min;
         mx  = duty_max;
         spd = mn;
         // linear ramp only when the thresholds are ordered; SV '/' truncates
         if (thr_safe > thr_warn)
            spd = mn + ((f - warn_q) * (mx - mn)) / (safe_q - warn_q);
         if (spd < mn)
            spd = mn;
         if (spd > mx)
            spd = mx;
         b.zone       = ZONE_WARN;
         b.drive_pct  = spd[6:0];
         b.led_yellow = 1'b1;
      end else begin
         b.zone         = ZONE_DANGER;
         b.drive_pct    = '0;
         b.brake        = 1'b1;
         b.buzzer_pulse = 1'b1;
         b.led_red      = 1'b1;
      end
      b.shown_cm = 9'((f + 128) >> 8);
      return b;
   endfunction

   // ---------------------------------------------------------------------
   // Scoreboard
   // ---------------------------------------------------------------------
   typedef struct {
      logic [15:0]  range_cm;
      rsp_beat_type beat;
   } pending_result_type;

   typedef struct {
      bit           typed;
      rsp_beat_type beat;
   } pinned_row_type;

   pending_result_type pending_results[$];  // oldest at the front
   pinned_row_type     pinned_rows[$];      // directed rows, one per reading
   int              mismatches    = 0;
   int              readings_in   = 0;
   int              results_out   = 0;
   int              zone_hits [3] = '{0, 0, 0};
   bit              req_idle_on   = 1'b0;
   bit              rsp_idle_on   = 1'b0;
   int              hold_off_cycles = 0;

   // Watches both channels at every rising edge. Results are retired before
   // the reading of the same edge is queued; a result never belongs to a
   // reading taken at that very edge.
   always @(posedge clock) begin : watch_beats
      rsp_beat_type       got;
      rsp_beat_type       want;
      pending_result_type entry;
      pinned_row_type     pin;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_beat_type'(rsp_tdata);
         results_out++;
         if (got.zone <= ZONE_DANGER)
            zone_hits[got.zone]++;
         if (pending_results.size() == 0) begin
            if (mismatches < 10)
               $display("%0t: result beat %h with no reading outstanding", $realtime, rsp_tdata);
            mismatches++;
         end else begin
            entry = pending_results.pop_front();
            want  = entry.beat;
            if (got !== want) begin
               if (mismatches < 10) begin
                  $display("%0t: mismatch for range_cm %0d", $realtime, entry.range_cm);
                  $display("   exp zone %0d drive %0d shown %0d brk %b buz %b yel %b red %b pad %b",
                           want.zone, want.drive_pct, want.shown_cm, want.brake,
                           want.buzzer_pulse, want.led_yellow, want.led_red, want.pad);
                  $display("   got zone %0d drive %0d shown %0d brk %b buz %b yel %b red %b pad %b",
                           got.zone, got.drive_pct, got.shown_cm, got.brake,
                           got.buzzer_pulse, got.led_yellow, got.led_red, got.pad);
               end
               mismatches++;
            end
         end
      end
      if (!reset && req_tvalid && req_tready) begin
         readings_in++;
         entry.range_cm = req_tdata;
         entry.beat     = governor_step(req_tdata);
         // directed rows with a typed-in answer override the predictor
         if (pinned_rows.size() != 0) begin
            pin = pinned_rows.pop_front();
            if (pin.typed)
               entry.beat = pin.beat;
         end
         pending_results.push_back(entry);
      end
   end

   // ---------------------------------------------------------------------
   // Idle gaps: mostly none or short, now and then long
   // ---------------------------------------------------------------------
   function automatic int draw_gap(input bit enabled);
      int roll;
      if (!enabled)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 85)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 12);
      return $urandom_range(25, 60);
   endfunction

   // Result side back-pressure. A requested hold-off keeps tready low for a
   // counted stretch so the output register fills and req_tready drops.
   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles != 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_off_cycles) @(negedge clock);
            hold_off_cycles = 0;
            rsp_tready <= 1'b1;
         end else if (stall_left != 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = draw_gap(rsp_idle_on);
         end
      end
   end

   // Offers one reading and returns at the edge that takes it. tvalid stays
   // up between back-to-back readings; it only drops for an idle gap.
   task automatic send_reading(input logic [15:0] range_cm);
      int gap;
      gap = draw_gap(req_idle_on);
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= range_cm;
      do
         @(posedge clock);
      while (!req_tready);
   endtask

   // Wait until every queued result is back, then let the sequencer settle.
   task automatic drain_results();
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int             target, hold, roll, value;
      pinned_row_type pin;

      thr_safe  = SAFE_THR_RST;
      thr_warn  = WARN_THR_RST;
      duty_safe = SAFE_SPD_RST;
      duty_min  = WARN_MIN_RST;
      duty_max  = WARN_MAX_RST;
      filt_q8   = SMOOTH_RST;
      target    = 200;
      hold      = 0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < N_PHASES; ph++) begin
         if (ph != 0) begin
            drain_results();
            for (int r = 0; r < 5; r++) begin
               @(negedge clock);
               csr_we    <= 1'b1;
               csr_addr  <= REG_ORDER[r];
               csr_wdata <= 9'(SETTING[ph][r]);
               unique case (REG_ORDER[r])
                  REG_SAFE_THR: thr_safe  = 9'(SETTING[ph][r]);
                  REG_WARN_THR: thr_warn  = 9'(SETTING[ph][r]);
                  REG_SAFE_SPD: duty_safe = 7'(SETTING[ph][r]);
                  REG_WARN_MIN: duty_min  = 7'(SETTING[ph][r]);
                  REG_WARN_MAX: duty_max  = 7'(SETTING[ph][r]);
                  default: ;
               endcase
            end
            @(negedge clock);
            csr_we <= 1'b0;
         end

         // vary who idles so each side also runs flat out for a while
         req_idle_on = (ph % 3) != 1;
         rsp_idle_on = (ph % 3) != 2;
         if (ph == PRESSURE_PHASE) begin
            req_idle_on     = 1'b0;
            hold_off_cycles = HOLD_OFF_LEN;
         end

         if (ph == 0) begin
            for (int i = 0; i < N_DIRECTED; i++) begin
               pin.typed          = i < PINNED_ROWS;
               pin.beat           = '0;
               pin.beat.zone      = ZONE_SAFE;
               pin.beat.drive_pct = SAFE_SPD_RST;
               if (i < PINNED_ROWS)
                  pin.beat.shown_cm = PINNED_SHOWN[i];
               pinned_rows.push_back(pin);
               send_reading(DIRECTED_RANGE[i]);
            end
         end

         // Random part: the reading hovers around a target that sits near
         // one of the thresholds or anywhere in range, so the filter keeps
         // crossing zone edges; a few beats are junk or out of window.
         for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
            if (hold == 0) begin
               case ($urandom_range(0, 2))
                  0:       target = int'(thr_warn) + int'($urandom_range(0, 40)) - 20;
                  1:       target = int'(thr_safe) + int'($urandom_range(0, 40)) - 20;
                  default: target = $urandom_range(2, 400);
               endcase
               if (target < 2)
                  target = 2;
               if (target > 400)
                  target = 400;
               hold = $urandom_range(3, 12);
            end
            hold--;
            roll = $urandom_range(0, 99);
            if (roll < 8)
               value = $urandom_range(0, 65535);
            else if (roll < 11)
               value = $urandom_range(0, 1);
            else
               value = target + int'($urandom_range(0, 8)) - 4;
            send_reading(16'(value));
         end

         @(negedge clock);
         req_tvalid <= 1'b0;
      end

      drain_results();

      $display("%0d readings, %0d results over %0d register settings incl. a %0d-cycle output stall",
               readings_in, results_out, N_PHASES, HOLD_OFF_LEN);
      $display("zones seen: safe %0d, warning %0d, danger %0d",
               zone_hits[ZONE_SAFE], zone_hits[ZONE_WARN], zone_hits[ZONE_DANGER]);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Watchdog: well beyond the slowest legal run
   initial begin : watchdog
      #5_000_000;
      $display("timeout, %0d results still outstanding", pending_results.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// File: filelist.f
sv/czsg_pkg.sv
sv/collision_zone_speed_governor.sv
test/tb_collision_zone_speed_governor.sv
